// File: src/html_entity_unescape_assert.svh
// Assertion macros shared by the entity unescaper modules.
`ifndef HTML_ENTITY_UNESCAPE_ASSERT_SVH
`define HTML_ENTITY_UNESCAPE_ASSERT_SVH

// Property holds at every clock edge outside reset.
`define HTEU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("html_entity_unescape: property violated");

// Condition must never be seen outside reset.
`define HTEU_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("html_entity_unescape: forbidden condition");

`endif

// File: src/hteu_pkg.sv
// Types and constants for the HTML entity unescaper.
`default_nettype none

package hteu_pkg;

	localparam int HOLD_DEPTH  = 5;
	localparam int MAX_OUT     = 6;
	localparam int NUM_ENT     = 6;
	localparam int ENT_LEN_MAX = 5;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] cnt_t;

	localparam byte_t AMP = 8'h26;

	// entity names after the ampersand, zero padded
	localparam byte_t ENT_TEXT [NUM_ENT][ENT_LEN_MAX] = '{
		'{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
		'{8'h23, 8'h33, 8'h39, 8'h3B, 8'h00},
		'{8'h23, 8'h34, 8'h37, 8'h3B, 8'h00},
		'{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B}
	};
	localparam cnt_t  ENT_LEN  [NUM_ENT] = '{3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5};
	localparam byte_t ENT_CHAR [NUM_ENT] = '{8'h3C, 8'h3E, 8'h26, 8'h27, 8'h2F, 8'h22};

	// one queued job: the output words caused by one input word
	typedef struct packed {
		byte_t [MAX_OUT-1:0] bytes;
		cnt_t                cnt;
		logic                eot;
	} job_t;

endpackage

`default_nettype wire

// File: src/hteu_front.sv
// Front end: holds entity candidates, classifies each input word into a job.
`default_nettype none

`include "html_entity_unescape_assert.svh"

module hteu_front import hteu_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   push,
	output logic  full,
	input  byte_t in_byte,
	input  wire   end_of_text,
	input  wire   q_full,
	output logic  job_push,
	output job_t  job
);

	cnt_t  cnt_q;
	cnt_t  cnt_nxt;
	byte_t held_q [1:HOLD_DEPTH-1];
	byte_t cand [HOLD_DEPTH];
	logic  complete;
	logic  prefix;
	byte_t comp_char;
	logic  wr_hold;
	logic  accept;
	logic  ent_ok [NUM_ENT];

	assign full   = q_full;
	assign accept = push && !q_full;

	// candidate = held bytes after the ampersand, then the new byte
	always_comb begin
		for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
			cand[i] = (3'(i + 1) < cnt_q) ? held_q[i + 1] : in_byte;
		end
		cand[HOLD_DEPTH-1] = in_byte;
	end

	always_comb begin
		complete  = 1'b0;
		prefix    = 1'b0;
		comp_char = AMP;
		for (int k = 0; k < NUM_ENT; k++) begin
			ent_ok[k] = (cnt_q <= ENT_LEN[k]);
			for (int i = 0; i < ENT_LEN_MAX; i++) begin
				if (3'(i) < cnt_q && cand[i] != ENT_TEXT[k][i])
					ent_ok[k] = 1'b0;
			end
			if (ent_ok[k]) begin
				if (cnt_q == ENT_LEN[k]) begin
					complete  = 1'b1;
					comp_char = ENT_CHAR[k];
				end else begin
					prefix = 1'b1;
				end
			end
		end
	end

	// job lanes: '&', held bytes, new byte; a completed entity uses lane 0 only
	always_comb begin
		job.eot      = end_of_text;
		job.bytes[0] = (cnt_q == 3'd0) ? in_byte : AMP;
		for (int i = 1; i < HOLD_DEPTH; i++) begin
			job.bytes[i] = (3'(i) < cnt_q) ? held_q[i] : in_byte;
		end
		job.bytes[MAX_OUT-1] = in_byte;
		wr_hold = 1'b0;
		cnt_nxt = 3'd0;
		job.cnt = 3'd0;
		priority if (cnt_q == 3'd0) begin
			if (in_byte == AMP) begin
				cnt_nxt = 3'd1;
				job.cnt = end_of_text ? 3'd1 : 3'd0;
			end else begin
				job.cnt = 3'd1;
			end
		end else if (complete) begin
			job.bytes[0] = comp_char;
			job.cnt      = 3'd1;
		end else if (prefix && cnt_q < 3'(HOLD_DEPTH)) begin
			wr_hold = 1'b1;
			cnt_nxt = cnt_q + 3'd1;
			job.cnt = end_of_text ? cnt_q + 3'd1 : 3'd0;
		end else begin
			// broken prefix; an ampersand not at end of text restarts the held run
			if (in_byte == AMP && !end_of_text) begin
				cnt_nxt = 3'd1;
				job.cnt = cnt_q;
			end else begin
				job.cnt = cnt_q + 3'd1;
			end
		end
		if (end_of_text)
			cnt_nxt = 3'd0;
	end

	assign job_push = accept && (job.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (accept) begin
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 1; i < HOLD_DEPTH; i++) begin
			if (accept && wr_hold && cnt_q == 3'(i))
				held_q[i] <= in_byte;
		end
	end

	`HTEU_NEVER(held_cnt_range, clk, arst_n, cnt_q > 3'(HOLD_DEPTH))
	`HTEU_ASSERT(eot_flushes, clk, arst_n, (accept && end_of_text) |=> (cnt_q == 3'd0))
	`HTEU_NEVER(push_into_full, clk, arst_n, job_push && q_full)

endmodule

`default_nettype wire

// File: src/hteu_queue.sv
// Short job queue between the classifying front end and the output back end.
`default_nettype none

`include "html_entity_unescape_assert.svh"

module hteu_queue import hteu_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   wr_en,
	input  job_t  wr_data,
	output logic  full,
	input  wire   rd_en,
	output job_t  rd_data,
	output logic  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	`HTEU_NEVER(count_overflow, clk, arst_n, count_q > CW'(DEPTH))

endmodule

`default_nettype wire

// File: src/hteu_back.sv
// Back end: plays out the words of each job in turn, one word per pop.
`default_nettype none

`include "html_entity_unescape_assert.svh"

module hteu_back import hteu_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   q_empty,
	input  job_t  q_data,
	output logic  q_pop,
	output logic  empty,
	input  wire   pop,
	output byte_t out_byte,
	output logic  run_last,
	output logic  text_end
);

	job_t cur_q;
	cnt_t idx_q;
	logic busy_q;
	logic last;
	logic load;

	assign last     = (idx_q == cur_q.cnt - 3'd1);
	assign load     = !busy_q || (pop && last);
	assign q_pop    = load && !q_empty;
	assign empty    = !busy_q;
	assign out_byte = cur_q.bytes[idx_q];
	assign run_last = last;
	assign text_end = last && cur_q.eot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (load) begin
			busy_q <= !q_empty;
			idx_q  <= 3'd0;
		end else if (pop) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_data;
	end

	`HTEU_ASSERT(job_in_range, clk, arst_n,
		busy_q |-> (cur_q.cnt != 3'd0 && idx_q < cur_q.cnt))
	`HTEU_ASSERT(load_sets_busy, clk, arst_n, q_pop |=> busy_q)

endmodule

`default_nettype wire

// File: src/html_entity_unescape.sv
// The first word caused by an input word is registered in the job queue and then in cur_q.
// Throughput: one input word per cycle while the job queue has room; the back end
// sends one output word per cycle while pop is high; a job of k results takes k pops.
// Entity bytes held in the front end give no output until the run resolves.
// Reset: held run cleared, job queue and output register empty.
`default_nettype none

module html_entity_unescape import hteu_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   push,
	output logic  full,
	input  byte_t in_byte,
	input  wire   end_of_text,
	output logic  empty,
	input  wire   pop,
	output byte_t out_byte,
	output logic  run_last,
	output logic  text_end
);

	logic job_push;
	job_t job_in;
	logic q_full;
	logic q_empty;
	logic q_pop;
	job_t job_out;

	hteu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.q_full     (q_full),
		.job_push   (job_push),
		.job        (job_in)
	);

	hteu_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_data(job_in),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_data(job_out),
		.empty  (q_empty)
	);

	hteu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (job_out),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.out_byte(out_byte),
		.run_last(run_last),
		.text_end(text_end)
	);

endmodule

`default_nettype wire
